/* rtl/crc16fc_pkg.sv */
// Shared types, constants and the byte-wise CRC step for the CRC-16 frame checker.
package crc16fc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam int unsigned HeldFull = 2;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } item_t;

  // Reflected CRC-16, eight bit steps for one byte.
  function automatic logic [15:0] crc16fc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/crc16_frame_check.sv */
// Top level of the CRC-16 frame checker: input register, CRC engine, result register.
//
// Takes one frame byte per beat on the slave stream (tlast marks the final
// byte) and gives one result beat per frame: the reflected CRC-16 (poly
// 0xA001, init 0xFFFF, no final XOR) in tdata, with tuser[0] = trailer match
// and tuser[1] = short frame. With trailer mode set, the last two bytes of a
// frame are the expected CRC, high byte first, and are not covered. A byte is
// accepted every cycle; the input stalls only while a last byte waits in the
// input register for the receiver to take the previous result. A last byte
// passes the input register, one eight-step CRC update and the result
// register before its result beat is valid.
// Writing the mode register clears any frame in progress.
module crc16_frame_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // trailer_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [15:0] frame_crc
  output logic [1:0]  m_axis_tuser     // [0] trailer_match, [1] short_frame
);
  import crc16fc_pkg::*;

  item_t s_item, item;
  logic  item_valid, item_take;
  logic  res_match, res_short;

  assign s_item.data_byte = s_axis_tdata;
  assign s_item.last_byte = s_axis_tlast;

  crc16fc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  crc16fc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_crc_o    (m_axis_tdata),
    .res_match_o  (res_match),
    .res_short_o  (res_short)
  );

  assign m_axis_tuser = {res_short, res_match};

  // A short frame never covers a byte and never matches.
  a_short_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_short |-> (m_axis_tdata == CrcInit) && !res_match)
    else $error("short frame with covered bytes or match");

  // Backpressure on the input only while a byte waits in the input register.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> item_valid)
    else $error("input stalled with empty input register");

  // A non-last byte never waits on the result register.
  a_mid_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !item.last_byte |-> item_take)
    else $error("mid-frame byte stalled");

  // A result beat appears only after a last byte was taken.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(item_take && item.last_byte))
    else $error("result without last byte");

endmodule

/* rtl/crc16fc_in_stage.sv */
// Input register: captures one byte beat and holds it until the engine takes it.
module crc16fc_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  crc16fc_pkg::item_t   s_item_i,
  output logic                 item_valid_o,
  output crc16fc_pkg::item_t   item_o,
  input  logic                 item_take_i
);
  import crc16fc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/crc16fc_engine.sv */
// Frame state (CRC register, trailer delay line) and the result register.
module crc16fc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 item_valid_i,
  input  crc16fc_pkg::item_t   item_i,
  output logic                 item_take_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [15:0]          res_crc_o,
  output logic                 res_match_o,
  output logic                 res_short_o
);
  import crc16fc_pkg::*;

  logic        mode_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  count_q, count_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_crc_q;
  logic        out_match_q, out_short_q;
  logic        out_free, take, full, covered;
  logic [7:0]  crc_byte_in;
  logic        match, short_f;

  assign out_free    = !out_valid_q || res_ready_i;
  assign take        = item_valid_i && (!item_i.last_byte || out_free);
  assign item_take_o = take;

  assign full        = (count_q == 2'(HeldFull));
  // In trailer mode the older held byte is covered once the delay line is full.
  assign covered     = !mode_q || full;
  assign crc_byte_in = mode_q ? held0_q : item_i.data_byte;

  always_comb begin
    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    count_d = count_q;
    if (covered) begin
      crc_d = crc16fc_byte(crc_q, crc_byte_in);
    end
    if (mode_q) begin
      if (full) begin
        held0_d = held1_q;
        held1_d = item_i.data_byte;
      end else begin
        if (count_q[0]) begin
          held1_d = item_i.data_byte;
        end else begin
          held0_d = item_i.data_byte;
        end
        count_d = count_q + 2'd1;
      end
    end
  end

  assign short_f = mode_q && (count_d != 2'(HeldFull));
  assign match   = mode_q && !short_f && ({held0_d, held1_d} == crc_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && item_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      crc_q       <= CrcInit;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      count_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // A mode write drops any frame in progress.
        mode_q  <= cfg_wdata_i;
        crc_q   <= CrcInit;
        held0_q <= 8'h00;
        held1_q <= 8'h00;
        count_q <= 2'd0;
      end else if (take) begin
        if (item_i.last_byte) begin
          crc_q   <= CrcInit;
          held0_q <= 8'h00;
          held1_q <= 8'h00;
          count_q <= 2'd0;
        end else begin
          crc_q   <= crc_d;
          held0_q <= held0_d;
          held1_q <= held1_d;
          count_q <= count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last_byte) begin
      out_crc_q   <= crc_d;
      out_match_q <= match;
      out_short_q <= short_f;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_crc_o   = out_crc_q;
  assign res_match_o = out_match_q;
  assign res_short_o = out_short_q;

endmodule

/* sim/tb_top.sv */
// Testbench for crc16_frame_check: frame stimulus, CRC predictor and result scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import crc16fc_pkg::*;

  typedef struct packed {
    logic [15:0] crc;
    logic        match;
    logic        short_f;
  } frame_result_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxShown   = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_wdata   = 1'b0;
  logic        s_valid     = 1'b0;
  logic [7:0]  s_data      = 8'h00;
  logic        s_last      = 1'b0;
  logic        m_ready     = 1'b0;
  logic        hold_req    = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  // stimulus bookkeeping
  item_t         byte_queue[$];
  item_t         next_beat;
  int unsigned   beats_queued   = 0;
  int unsigned   beats_accepted = 0;
  bit            mode_sel       = 1'b0;
  int unsigned   mode_writes    = 0;

  // predictor state
  frame_result_t crc_expect[$];
  frame_result_t exp_r;
  logic          trailer_on;
  logic [15:0]   acc_crc;
  logic [7:0]    held_old;
  logic [7:0]    held_new;
  logic [1:0]    held_n;
  int unsigned   frames_checked = 0;
  int unsigned   errors         = 0;

  crc16_frame_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Reflected CRC-16, one data bit per step, LSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  function automatic void clear_frame();
    acc_crc  = CrcInit;
    held_old = 8'h00;
    held_new = 8'h00;
    held_n   = 2'd0;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    frame_result_t r;
    if (trailer_on) begin
      // the older held byte leaves the delay line once it is full
      if (held_n == 2'd2) begin
        acc_crc  = crc_step(acc_crc, held_old);
        held_old = held_new;
        held_new = b;
      end else if (held_n == 2'd0) begin
        held_old = b;
        held_n   = 2'd1;
      end else begin
        held_new = b;
        held_n   = 2'd2;
      end
    end else begin
      acc_crc = crc_step(acc_crc, b);
    end
    if (is_last) begin
      r.crc     = acc_crc;
      r.match   = 1'b0;
      r.short_f = 1'b0;
      if (trailer_on) begin
        if (held_n < 2'd2) begin
          r.short_f = 1'b1;
        end else begin
          r.match = ({held_old, held_new} == acc_crc);
        end
      end
      crc_expect.push_back(r);
      clear_frame();
    end
  endtask

  // Driver: advance to the next beat once the current one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_axis_tready) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = byte_queue.pop_front();
        s_valid <= 1'b1;
        s_data  <= next_beat.data_byte;
        s_last  <= next_beat.last_byte;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on input beats and config writes, check on output beats.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      trailer_on = 1'b0;
      clear_frame();
    end else begin
      if (cfg_we) begin
        trailer_on = cfg_wdata;
        clear_frame();
      end
      if (s_valid && s_axis_tready) begin
        beats_accepted++;
        predict_byte(s_data, s_last);
      end
      if (m_axis_tvalid && m_ready) begin
        if (crc_expect.size() == 0) begin
          errors++;
          if (errors <= MaxShown) begin
            $display("ERROR: unexpected result crc=%h match=%b short=%b",
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
          end
        end else begin
          exp_r = crc_expect.pop_front();
          frames_checked++;
          if (m_axis_tdata !== exp_r.crc || m_axis_tuser[0] !== exp_r.match ||
              m_axis_tuser[1] !== exp_r.short_f) begin
            errors++;
            if (errors <= MaxShown) begin
              $display({"ERROR: frame %0d crc exp %h got %h, match exp %b got %b,",
                        " short exp %b got %b"},
                       frames_checked, exp_r.crc, m_axis_tdata, exp_r.match,
                       m_axis_tuser[0], exp_r.short_f, m_axis_tuser[1]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_cnt, crc_expect.size());
      $display("crc16_frame_check test failed");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic is_last);
    item_t it;
    it.data_byte = b;
    it.last_byte = is_last;
    byte_queue.push_back(it);
    beats_queued++;
  endtask

  // Queue one frame; with_crc appends a correct trailer (rarely corrupted).
  task automatic queue_frame(input int len, input bit with_crc, input bit close);
    logic [7:0]  fbytes[$];
    logic [15:0] c;
    int          fill;
    int          body;
    fill = $urandom_range(9);
    body = with_crc ? len - 2 : len;
    for (int k = 0; k < body; k++) begin
      if (fill == 0) begin
        fbytes.push_back(8'h00);
      end else if (fill == 1) begin
        fbytes.push_back(8'hFF);
      end else begin
        fbytes.push_back(8'($urandom_range(255)));
      end
    end
    if (with_crc) begin
      c = CrcInit;
      foreach (fbytes[k]) begin
        c = crc_step(c, fbytes[k]);
      end
      fbytes.push_back(c[15:8]);
      fbytes.push_back(c[7:0]);
      if ($urandom_range(7) == 0) begin
        fbytes[$urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
      end
    end
    foreach (fbytes[k]) begin
      push_beat(fbytes[k], close && (k == len - 1));
    end
  endtask

  task automatic wait_idle();
    while (beats_accepted != beats_queued || crc_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit v);
    wait_idle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    mode_sel = v;
    mode_writes++;
  endtask

  task automatic random_batch(input int unsigned target);
    int unsigned n;
    int          len;
    int unsigned r;
    n = 0;
    while (n < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        len = $urandom_range(8, 1);
      end else if (r < 90) begin
        len = $urandom_range(24, 9);
      end else begin
        len = $urandom_range(64, 25);
      end
      queue_frame(len, mode_sel && len >= 2 && $urandom_range(99) < 70, 1'b1);
      n += len;
    end
    // leave a frame open half the time so the next mode write aborts it
    if ($urandom_range(1) == 1) begin
      queue_frame($urandom_range(5, 1), 1'b0, 1'b0);
    end
  endtask

  task automatic short_batch(input int unsigned target);
    int unsigned n;
    int          len;
    n = 0;
    while (n < target) begin
      len = $urandom_range(4, 1);
      queue_frame(len, mode_sel && len >= 2 && $urandom_range(1) == 1, 1'b1);
      n += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain mode extremes and the standard check string
    set_mode(1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    for (int k = 0; k < 9; k++) begin
      push_beat(8'h31 + 8'(k), k == 8);
    end
    // directed: trailer mode short frame, trailer-only frame, good frame
    set_mode(1'b1);
    push_beat(8'hA5, 1'b1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b1);
    queue_frame(5, 1'b1, 1'b1);
    // drop an open frame through a mode write
    push_beat(8'h12, 1'b0);
    push_beat(8'h34, 1'b0);
    push_beat(8'h56, 1'b0);
    set_mode(1'b1);
    push_beat(8'h80, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      @(posedge clk_i);
      send_idle_pct <= (ph == 0) ? 24 : (ph == 1) ? 77 : 0;
      recv_idle_pct <= (ph == 0) ? 77 : (ph == 1) ? 24 : 0;
      for (int bt = 0; bt < 2; bt++) begin
        set_mode((ph + bt) % 2 == 1);
        if (ph == 2 && bt == 0) begin
          // stall the output long enough to back up the input
          short_batch(60);
          hold_req <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
          random_batch(30);
        end else begin
          random_batch(70);
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d input beats and %0d frame results over %0d mode writes,",
             beats_accepted, frames_checked, mode_writes);
    $display("plain and trailer modes, short and aborted frames, with stalls on both sides.");
    if (errors == 0 && crc_expect.size() == 0) begin
      $display("crc16_frame_check test passed");
    end else begin
      $display("%0d failures, %0d results missing", errors, crc_expect.size());
      $display("crc16_frame_check test failed");
    end
    $finish;
  end

endmodule
